>>> rtl/envds_pkg.sv
// Shared constants and types for the envelope dry/wet splicer.
// Used by envelope_dry_wet_splicer_core; depends on nothing else.
`default_nettype none

package envds_pkg;

    // Width of the dry, wet and mixed audio samples.
    localparam int SAMPLE_BITS = 16;

    // Q1.15 weights: full scale is 1.0 and needs 16 bits unsigned.
    localparam int Q_BITS = 16;
    localparam logic [Q_BITS-1:0] Q_ONE     = 16'd32768;
    localparam logic [Q_BITS-1:0] TRIG_HALF = 16'd16384;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_RISE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_FALL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOTE_END    = 2'd2;

    // Reset values of the step registers.
    localparam logic [Q_BITS-1:0] RISE_STEP_RST = 16'd683;
    localparam logic [Q_BITS-1:0] FALL_STEP_RST = 16'd14;
    localparam logic [Q_BITS-1:0] NOTE_STEP_RST = 16'd14;

    // Attack envelope phase codes.
    localparam int PH_BITS = 2;
    localparam logic [PH_BITS-1:0] PH_IDLE    = 2'd0;
    localparam logic [PH_BITS-1:0] PH_RISING  = 2'd1;
    localparam logic [PH_BITS-1:0] PH_FALLING = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [Q_BITS-1:0]             t_q;
    // Product of a sample and a weight in 0..1.0.
    typedef logic signed [SAMPLE_BITS+Q_BITS:0] t_prod;

    // A step of zero counts as one, anything above full scale as full scale.
    function automatic t_q clamp_step(input logic [Q_BITS-1:0] s);
        t_q r;
        if (s == '0) begin
            r = t_q'(1);
        end else if (s > Q_ONE) begin
            r = Q_ONE;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/envelope_dry_wet_splicer_core.sv
// Envelope dry/wet splicer: attack and note-end envelopes driving a dry/wet blend.
// Uses envds_pkg for widths, codes and the step clamp.
//
//  Channel  | Signals                                           | Direction
//  ---------+---------------------------------------------------+----------
//  input    | i_valid, o_stall, i_dry_sample, i_wet_sample,     | in
//           | i_trigger_level, i_dive_target                    |
//  output   | o_valid, i_stall, o_mixed_sample, o_dry_fraction  | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// One item can be accepted in every cycle through a four-stage pipeline: input register,
// envelope update, two products, sum with rounding and saturation. Each item passes these
// stages in order, and its result is held in the output register. Each stage holds
// while the next one is full and stalled, so bubbles are squeezed out; the input stalls
// only when all four stages are full and the output is stalled. Synchronous active-low
// reset empties the pipeline, idles the envelopes and restores the step registers.
`default_nettype none

module envelope_dry_wet_splicer_core (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // input channel
    input  wire                                      i_valid,
    output logic                                     o_stall,
    input  wire signed [envds_pkg::SAMPLE_BITS-1:0]  i_dry_sample,
    input  wire signed [envds_pkg::SAMPLE_BITS-1:0]  i_wet_sample,
    input  wire        [envds_pkg::Q_BITS-1:0]       i_trigger_level,
    input  wire        [envds_pkg::Q_BITS-1:0]       i_dive_target,
    // output channel
    output logic                                     o_valid,
    input  wire                                      i_stall,
    output logic signed [envds_pkg::SAMPLE_BITS-1:0] o_mixed_sample,
    output logic        [envds_pkg::Q_BITS-1:0]      o_dry_fraction,
    // configuration
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire        [envds_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire        [envds_pkg::Q_BITS-1:0]       i_cfg_data
);

    localparam int SB   = envds_pkg::SAMPLE_BITS;
    localparam int QB   = envds_pkg::Q_BITS;
    localparam int SUMW = SB + QB + 2;
    localparam int RNDW = SUMW - (QB - 1);

    // Step registers, stored already clamped.
    envds_pkg::t_q r_rise_step, r_fall_step, r_note_step;

    // Envelope state.
    logic [envds_pkg::PH_BITS-1:0] r_phase, n_phase;
    envds_pkg::t_q                 r_att_env, n_att_env;
    envds_pkg::t_q                 r_ne_env, n_ne_env;
    logic                          r_trig_high, n_trig_high;

    // Pipeline stages.
    logic                 r_a_vld, r_b_vld, r_c_vld, r_o_vld;
    envds_pkg::t_sample   r_a_dry, r_a_wet;
    envds_pkg::t_q        r_a_trig, r_a_target;
    envds_pkg::t_sample   r_b_dry, r_b_wet;
    envds_pkg::t_q        r_b_mix, n_mix;
    envds_pkg::t_prod     r_c_pdry, r_c_pwet, n_pdry, n_pwet;
    envds_pkg::t_q        r_c_mix;
    envds_pkg::t_sample   r_o_mixed, n_mixed;
    envds_pkg::t_q        r_o_frac;

    logic free_a, free_b, free_c, free_o;

    logic                  high;
    logic [QB:0]           att_up, ne_up;
    envds_pkg::t_q         target, ne_down;
    logic signed [QB:0]    w_dry, w_wet;
    logic signed [SUMW-1:0] acc;
    logic signed [RNDW-1:0] rnd;

    assign free_o = !r_o_vld || !i_stall;
    assign free_c = !r_c_vld || free_o;
    assign free_b = !r_b_vld || free_c;
    assign free_a = !r_a_vld || free_b;

    assign o_stall        = !free_a;
    assign o_valid        = r_o_vld;
    assign o_mixed_sample = r_o_mixed;
    assign o_dry_fraction = r_o_frac;
    assign o_cfg_ready    = 1'b1;

    // Envelope update for the item leaving the input register.
    always_comb begin
        high        = r_a_trig > envds_pkg::TRIG_HALF;
        n_trig_high = high;
        n_phase     = (high && !r_trig_high) ? envds_pkg::PH_RISING : r_phase;
        n_att_env   = r_att_env;
        att_up      = {1'b0, r_att_env} + {1'b0, r_rise_step};

        case (n_phase)
            envds_pkg::PH_RISING: begin
                if (att_up >= {1'b0, envds_pkg::Q_ONE}) begin
                    n_att_env = envds_pkg::Q_ONE;
                    n_phase   = envds_pkg::PH_FALLING;
                end else begin
                    n_att_env = att_up[QB-1:0];
                end
            end
            envds_pkg::PH_FALLING: begin
                if (r_att_env <= r_fall_step) begin
                    n_att_env = '0;
                    n_phase   = envds_pkg::PH_IDLE;
                end else begin
                    n_att_env = r_att_env - r_fall_step;
                end
            end
            default: begin
                n_phase = envds_pkg::PH_IDLE;
            end
        endcase

        target  = (r_a_target > envds_pkg::Q_ONE) ? envds_pkg::Q_ONE : r_a_target;
        ne_up   = {1'b0, r_ne_env} + {1'b0, r_note_step};
        ne_down = (r_ne_env > r_note_step) ? (r_ne_env - r_note_step) : '0;
        if (target > r_ne_env) begin
            n_ne_env = (ne_up < {1'b0, target}) ? ne_up[QB-1:0] : target;
        end else begin
            n_ne_env = (ne_down > target) ? ne_down : target;
        end

        n_mix = (n_att_env > n_ne_env) ? n_att_env : n_ne_env;
    end

    // Products of the blend; both weights are in 0..1.0.
    always_comb begin
        w_dry  = $signed({1'b0, r_b_mix});
        w_wet  = $signed({1'b0, envds_pkg::Q_ONE - r_b_mix});
        n_pdry = envds_pkg::t_prod'(r_b_dry * w_dry);
        n_pwet = envds_pkg::t_prod'(r_b_wet * w_wet);
    end

    // Sum, round half up, saturate.
    always_comb begin
        acc = SUMW'(r_c_pdry) + SUMW'(r_c_pwet) + SUMW'(1 <<< (QB - 2));
        rnd = RNDW'(acc >>> (QB - 1));
        if (rnd[RNDW-1:SB-1] == '0 || rnd[RNDW-1:SB-1] == '1) begin
            n_mixed = rnd[SB-1:0];
        end else if (rnd[RNDW-1]) begin
            n_mixed = {1'b1, {(SB-1){1'b0}}};
        end else begin
            n_mixed = {1'b0, {(SB-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_step <= envds_pkg::RISE_STEP_RST;
            r_fall_step <= envds_pkg::FALL_STEP_RST;
            r_note_step <= envds_pkg::NOTE_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                envds_pkg::CFG_ATTACK_RISE: r_rise_step <= envds_pkg::clamp_step(i_cfg_data);
                envds_pkg::CFG_ATTACK_FALL: r_fall_step <= envds_pkg::clamp_step(i_cfg_data);
                envds_pkg::CFG_NOTE_END:    r_note_step <= envds_pkg::clamp_step(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= envds_pkg::PH_IDLE;
            r_att_env   <= '0;
            r_ne_env    <= '0;
            r_trig_high <= 1'b0;
        end else if (r_a_vld && free_b) begin
            r_phase     <= n_phase;
            r_att_env   <= n_att_env;
            r_ne_env    <= n_ne_env;
            r_trig_high <= n_trig_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (free_a) r_a_vld <= i_valid;
            if (free_b) r_b_vld <= r_a_vld;
            if (free_c) r_c_vld <= r_b_vld;
            if (free_o) r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_a) begin
            r_a_dry    <= i_dry_sample;
            r_a_wet    <= i_wet_sample;
            r_a_trig   <= i_trigger_level;
            r_a_target <= i_dive_target;
        end
        if (free_b) begin
            r_b_dry <= r_a_dry;
            r_b_wet <= r_a_wet;
            r_b_mix <= n_mix;
        end
        if (free_c) begin
            r_c_pdry <= n_pdry;
            r_c_pwet <= n_pwet;
            r_c_mix  <= r_b_mix;
        end
        if (free_o) begin
            r_o_mixed <= n_mixed;
            r_o_frac  <= r_c_mix;
        end
    end

endmodule

`default_nettype wire
